>>> design/lst_pkg.sv
// shared types and timing constants for the lcd scanline timing block
package lst_pkg;

	localparam int LINE_CYCLES = 456;
	localparam int OAM_CYCLES = 80;
	localparam int OAM_XFER_CYCLES = 252;

	localparam int CNT_W = $clog2(LINE_CYCLES + 1);
	localparam int LINE_W = 8;
	localparam int CYC_W = 8;

	localparam logic [CNT_W-1:0] CNT_RELOAD = CNT_W'(LINE_CYCLES);
	localparam logic [CNT_W-1:0] OAM_START = CNT_W'(LINE_CYCLES - OAM_CYCLES);
	localparam logic [CNT_W-1:0] XFER_START = CNT_W'(LINE_CYCLES - OAM_XFER_CYCLES);

	localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
	localparam logic [LINE_W-1:0] LAST_LINE = 8'd153;

	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 16;
	localparam int APB_ADDR_W = 3;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM = 2'd2,
		MODE_XFER = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CYC_W-1:0] cycle_count;
		logic lcd_on;
		logic hblank_int_enable;
		logic vblank_int_enable;
		logic oam_int_enable;
		logic match_int_enable;
		logic [LINE_W-1:0] compare_line;
		logic cpu_halted;
	} tick_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		mode_t lcd_mode;
		logic coincidence;
		logic vblank_irq;
		logic stat_irq;
		logic render_request;
		logic hdma_request;
	} result_t;

endpackage

>>> design/lst_cfg_regs.sv
// apb register file holding the color mode bit
module lst_cfg_regs import lst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic                  color_mode
);

	logic color_mode_q;
	logic sel_color;

	// register 0 covers byte addresses 0..3
	assign sel_color = (paddr[APB_ADDR_W-1] == 1'b0);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && sel_color) begin
			color_mode_q <= pwdata[0];
		end
	end

	assign prdata = sel_color ? {31'd0, color_mode_q} : 32'd0;
	assign color_mode = color_mode_q;

endmodule

>>> design/lst_timing.sv
// line counter, ly, mode and stat interrupt logic for one tick
module lst_timing import lst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  tick_t   tick,
	input  logic    color_mode,
	output result_t result
);

	logic [CNT_W-1:0]  cycles_left_q;
	logic [LINE_W-1:0] line_q;
	mode_t             stored_mode_q;
	logic              match_q;

	logic [CNT_W-1:0]  cnt_d;
	logic [LINE_W-1:0] line_d;
	mode_t             mode_d;
	mode_t             mode_cur;
	logic              match_d;
	logic              enabled;
	logic              vblank_irq;
	logic              stat_irq;
	logic              render;
	logic              hdma;
	logic [CNT_W-1:0]  cyc_ext;

	assign cyc_ext = CNT_W'(tick.cycle_count);

	always_comb begin
		cnt_d = cycles_left_q;
		line_d = line_q;
		mode_d = stored_mode_q;
		mode_cur = MODE_HBLANK;
		match_d = match_q;
		enabled = 1'b0;
		vblank_irq = 1'b0;
		stat_irq = 1'b0;
		render = 1'b0;
		hdma = 1'b0;
		if (!tick.lcd_on) begin
			cnt_d = CNT_RELOAD;
			line_d = '0;
			mode_d = MODE_HBLANK;
		end else begin
			// mode from the counter before this tick
			priority if (line_q >= VBLANK_LINE) begin
				mode_cur = MODE_VBLANK;
				enabled = tick.vblank_int_enable;
			end else if (cycles_left_q >= OAM_START) begin
				mode_cur = MODE_OAM;
				enabled = tick.oam_int_enable;
			end else if (cycles_left_q >= XFER_START) begin
				mode_cur = MODE_XFER;
			end else begin
				mode_cur = MODE_HBLANK;
				enabled = tick.hblank_int_enable;
				hdma = color_mode && tick.cpu_halted;
			end
			stat_irq = enabled && (mode_cur != stored_mode_q);
			mode_d = mode_cur;

			if (cyc_ext >= cycles_left_q) begin
				// line done, surplus cycles dropped
				cnt_d = CNT_RELOAD;
				line_d = (line_q >= LAST_LINE) ? '0 : line_q + 8'd1;
				if (line_d == VBLANK_LINE) begin
					vblank_irq = 1'b1;
				end else if (line_d < VBLANK_LINE) begin
					render = 1'b1;
					match_d = (line_d == tick.compare_line);
					if (match_d && tick.match_int_enable) begin
						stat_irq = 1'b1;
					end
				end
			end else begin
				cnt_d = cycles_left_q - cyc_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_left_q <= CNT_RELOAD;
			line_q <= '0;
			stored_mode_q <= MODE_HBLANK;
			match_q <= 1'b0;
		end else if (fire) begin
			cycles_left_q <= cnt_d;
			line_q <= line_d;
			stored_mode_q <= mode_d;
			match_q <= match_d;
		end
	end

	assign result.line = line_d;
	assign result.lcd_mode = mode_d;
	assign result.coincidence = match_d;
	assign result.vblank_irq = vblank_irq;
	assign result.stat_irq = stat_irq;
	assign result.render_request = render;
	assign result.hdma_request = hdma;

endmodule

>>> design/lcd_scanline_timing_stat_core.sv
// top level: stream ports, input and result registers, apb config
// path: a request accepted into the input register passes through the timing
//   logic into the result register, which drives m_tdata until m_tready takes it
// throughput: one request per cycle while m_tready is high; the line counter and
//   ly state update in logic between the input register and the result register
// reset: arst_n clears both pipeline stages, counter reloads to 456, line and
//   mode go to 0, coincidence and color mode clear
module lcd_scanline_timing_stat_core import lst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cycle_count[7:0], lcd_on[8], hblank_int_enable[9], vblank_int_enable[10],
	// oam_int_enable[11], match_int_enable[12], compare_line[20:13],
	// cpu_halted[21], zero[23:22]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// result out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// line[7:0], lcd_mode[9:8], coincidence[10], vblank_irq[11], stat_irq[12],
	// render_request[13], hdma_request[14], zero[15]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic    valid_s1;
	tick_t   tick_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_d;
	tick_t   tick_in;
	logic    advance;
	logic    color_mode;

	// unpack the request fields from the low bits up
	assign tick_in.cycle_count = s_tdata[7:0];
	assign tick_in.lcd_on = s_tdata[8];
	assign tick_in.hblank_int_enable = s_tdata[9];
	assign tick_in.vblank_int_enable = s_tdata[10];
	assign tick_in.oam_int_enable = s_tdata[11];
	assign tick_in.match_int_enable = s_tdata[12];
	assign tick_in.compare_line = s_tdata[20:13];
	assign tick_in.cpu_halted = s_tdata[21];

	// stage 1 moves into the result register when that slot is free or draining
	assign advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= tick_in;
		end
	end

	lst_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.color_mode (color_mode)
	);

	// timing state advances exactly once per request, as it enters stage 2
	lst_timing u_timing (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.tick       (tick_s1),
		.color_mode (color_mode),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {1'b0,
		result_s2.hdma_request,
		result_s2.render_request,
		result_s2.stat_irq,
		result_s2.vblank_irq,
		result_s2.coincidence,
		result_s2.lcd_mode,
		result_s2.line};

endmodule
